>>> src/gdc_pkg.sv
// gdc_pkg: shared constants, types and codes for the grid dda wall column caster
// used by the controller, the datapath, the divider and the top level
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

  // map, texture and walk bounds
  localparam int MAP_SIDE    = 64;
  localparam int MAP_BITS    = $clog2(MAP_SIDE);
  localparam int MAP_DEPTH   = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W      = 2 * MAP_BITS;
  localparam int MAPC_W      = MAP_BITS + 2;
  localparam int CELL_W      = 9;
  localparam int TEX_SIZE    = 64;
  localparam int TEX_BITS    = $clog2(TEX_SIZE);
  localparam int MAX_COLUMNS = 1024;
  localparam int ROWS_MAX    = 1024;
  localparam int MAX_STEPS   = 128;
  localparam int STEP_W      = $clog2(MAX_STEPS + 1);

  // field and register widths
  localparam int POS_W     = 22;
  localparam int DIR_W     = 18;
  localparam int SIZE_W    = 11;
  localparam int COL_W     = 10;
  localparam int CFG_W     = 22;
  localparam int REG_IDX_W = 3;
  localparam int TEXID_W   = 8;
  localparam int CELLC_W   = 6;

  // internal datapath widths
  localparam int DIVN_W  = 34;
  localparam int DIVD_W  = 30;
  localparam int DCNT_W  = $clog2(DIVN_W + 1);
  localparam int CAM_W   = 29;
  localparam int RAY_W   = 31;
  localparam int DELTA_W = 34;
  localparam int SIDE_W  = 42;
  localparam int DIST_W  = 24;
  localparam int LH_W    = 27;
  localparam int ROW_W   = 10;
  localparam int STP_W   = 23;
  localparam int TP_W    = 26;

  // fixed point constants
  localparam logic [CAM_W-1:0]   FONE      = CAM_W'(65536);
  localparam logic [DIVN_W-1:0]  DIV_ONE32 = DIVN_W'(64'h1_0000_0000);
  localparam logic [DIVN_W-1:0]  TEX_NUM   = DIVN_W'(TEX_SIZE * 65536);
  localparam logic [DELTA_W-1:0] DELTA_SAT = DELTA_W'(64'h2_0000_0000);
  localparam logic [DIST_W-1:0]  DIST_MAX  = DIST_W'(24'hFF_FFFF);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CAM_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAM_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SCR_W   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SCR_H   = 3'd7;

  // register reset values
  localparam logic [POS_W-1:0]  RST_CAM_X   = POS_W'(2097152);
  localparam logic [POS_W-1:0]  RST_CAM_Y   = POS_W'(2097152);
  localparam logic [DIR_W-1:0]  RST_DIR_X   = DIR_W'(65536);
  localparam logic [DIR_W-1:0]  RST_DIR_Y   = DIR_W'(0);
  localparam logic [DIR_W-1:0]  RST_PLANE_X = DIR_W'(0);
  localparam logic [DIR_W-1:0]  RST_PLANE_Y = DIR_W'(43253);
  localparam logic [SIZE_W-1:0] RST_SCR_W   = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RST_SCR_H   = SIZE_W'(480);

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAMX,
    ST_RAYX,
    ST_RAYY,
    ST_DLX,
    ST_DLY,
    ST_SDX,
    ST_SDY,
    ST_STEP,
    ST_CHECK,
    ST_LH,
    ST_WALL,
    ST_STP,
    ST_TEXP,
    ST_DONE,
    ST_MISS
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_WRITE,
    CMD_CAST,
    CMD_CAMX,
    CMD_RAYX,
    CMD_RAYY,
    CMD_DLX,
    CMD_DLY,
    CMD_SDX,
    CMD_SDY,
    CMD_STEP,
    CMD_PERP,
    CMD_LH,
    CMD_WALL,
    CMD_STP,
    CMD_TEXP,
    CMD_OUT_HIT,
    CMD_OUT_MISS
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clear_last;
    logic out_free;
    logic map_oob;
    logic map_wall;
    logic steps_done;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/gdc_div.sv
// gdc_div: restoring unsigned divider, one quotient bit per cycle
// depends on gdc_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module gdc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gdc_pkg::DIVN_W-1:0]  dividend,
  input  logic [gdc_pkg::DIVD_W-1:0]  divisor,
  output logic                        done,
  output logic [gdc_pkg::DIVN_W-1:0]  quotient
);
  import gdc_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] count;
  logic [DIVD_W-1:0] rem;
  logic [DIVD_W-1:0] den;
  logic [DIVD_W:0]   trial;
  logic [DIVD_W:0]   diff;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem, quotient[DIVN_W-1]};
  assign diff  = trial - {1'b0, den};
  assign done  = ~busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DCNT_W'(DIVN_W);
    end else if (busy) begin
      count <= count - DCNT_W'(1);
      if (count == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[DIVD_W]) begin
        rem      <= diff[DIVD_W-1:0];
        quotient <= {quotient[DIVN_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DIVD_W-1:0];
        quotient <= {quotient[DIVN_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> src/gdc_ctrl.sv
// gdc_ctrl: sequencer for map writes, the clearing pass and the cast steps
// depends on gdc_pkg for state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module gdc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 op,
  input  gdc_pkg::dp_status_t  status,
  output logic                 in_stall,
  output gdc_pkg::cmd_t        cmd
);
  import gdc_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd = CMD_CLEAR;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_CAST) begin
            cmd        = CMD_CAST;
            state_next = ST_CAMX;
          end else begin
            cmd = CMD_WRITE;
          end
        end
      end
      ST_CAMX: begin
        if (status.div_done) begin
          cmd        = CMD_CAMX;
          state_next = ST_RAYX;
        end
      end
      ST_RAYX: begin
        cmd        = CMD_RAYX;
        state_next = ST_RAYY;
      end
      ST_RAYY: begin
        cmd        = CMD_RAYY;
        state_next = ST_DLX;
      end
      ST_DLX: begin
        if (status.div_done) begin
          cmd        = CMD_DLX;
          state_next = ST_DLY;
        end
      end
      ST_DLY: begin
        if (status.div_done) begin
          cmd        = CMD_DLY;
          state_next = ST_SDX;
        end
      end
      ST_SDX: begin
        cmd        = CMD_SDX;
        state_next = ST_SDY;
      end
      ST_SDY: begin
        cmd        = CMD_SDY;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd        = CMD_STEP;
        state_next = ST_CHECK;
      end
      // map cell of the last step is in the read register now
      ST_CHECK: begin
        if (status.map_oob) begin
          state_next = ST_MISS;
        end else if (status.map_wall) begin
          cmd        = CMD_PERP;
          state_next = ST_LH;
        end else if (status.steps_done) begin
          state_next = ST_MISS;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_LH: begin
        if (status.div_done) begin
          cmd        = CMD_LH;
          state_next = ST_WALL;
        end
      end
      ST_WALL: begin
        cmd        = CMD_WALL;
        state_next = ST_STP;
      end
      ST_STP: begin
        if (status.div_done) begin
          cmd        = CMD_STP;
          state_next = ST_TEXP;
        end
      end
      ST_TEXP: begin
        cmd        = CMD_TEXP;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd        = CMD_OUT_HIT;
          state_next = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (status.out_free) begin
          cmd        = CMD_OUT_MISS;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/gdc_dp.sv
// gdc_dp: camera registers, map memory, ray setup, dda walk and wall math
// depends on gdc_pkg and gdc_div
`timescale 1ns / 1ps
`default_nettype none

module gdc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  gdc_pkg::cmd_t                 cmd,
  output gdc_pkg::dp_status_t           status,
  input  logic                          cfg_write,
  input  logic [gdc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [gdc_pkg::CFG_W-1:0]     cfg_data,
  input  logic [gdc_pkg::CELLC_W-1:0]   cell_x,
  input  logic [gdc_pkg::CELLC_W-1:0]   cell_y,
  input  logic [gdc_pkg::TEXID_W-1:0]   cell_texture,
  input  logic                          cell_decoration,
  input  logic [gdc_pkg::COL_W-1:0]     column,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          hit_found,
  output logic                          hit_side,
  output logic [gdc_pkg::TEXID_W-1:0]   wall_texture,
  output logic [gdc_pkg::DIST_W-1:0]    perp_distance,
  output logic [gdc_pkg::ROW_W-1:0]     span_start,
  output logic [gdc_pkg::ROW_W-1:0]     span_end,
  output logic [gdc_pkg::TEX_BITS-1:0]  texel_column,
  output logic [gdc_pkg::STP_W-1:0]     texel_step,
  output logic [gdc_pkg::TP_W-1:0]      texel_start
);
  import gdc_pkg::*;

  // camera registers
  logic        [POS_W-1:0]  cam_x;
  logic        [POS_W-1:0]  cam_y;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;
  logic signed [DIR_W-1:0]  plane_x;
  logic signed [DIR_W-1:0]  plane_y;
  logic        [SIZE_W-1:0] scr_w;
  logic        [SIZE_W-1:0] scr_h;
  logic        [SIZE_W-1:0] w_size;
  logic        [SIZE_W-1:0] h_size;

  // divider
  logic              div_start;
  logic [DIVN_W-1:0] div_num;
  logic [DIVD_W-1:0] div_den;
  logic              div_done;
  logic [DIVN_W-1:0] div_q;

  // ray setup
  logic signed [CAM_W-1:0]       camx;
  logic signed [RAY_W-1:0]       rdx;
  logic signed [RAY_W-1:0]       rdy;
  logic signed [DIR_W-1:0]       psel;
  logic signed [RAY_W-1:0]       dsel;
  logic signed [CAM_W+DIR_W-1:0] ray_prod;
  logic        [RAY_W-1:0]       ray_new;
  logic        [RAY_W-1:0]       abs_x;
  logic        [RAY_W-1:0]       abs_y;
  logic        [DIVD_W-1:0]      den_x;
  logic        [DIVD_W-1:0]      den_y;

  // walk
  logic [DELTA_W-1:0]      dlx;
  logic [DELTA_W-1:0]      dly;
  logic [SIDE_W-1:0]       sdx;
  logic [SIDE_W-1:0]       sdy;
  logic [16:0]             sd_term;
  logic [DELTA_W-1:0]      sd_delta;
  logic [DELTA_W+16:0]     sd_prod;
  logic [15:0]             sd_frac;
  logic                    sd_neg;
  logic [MAPC_W-1:0]       mapx;
  logic [MAPC_W-1:0]       mapy;
  logic [MAPC_W-1:0]       mapx_step;
  logic [MAPC_W-1:0]       mapy_step;
  logic [STEP_W-1:0]       steps;
  logic                    side;
  logic                    take_x;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic [CELL_W-1:0]       wr_data;
  logic                    wr_en;
  logic [ADDR_W-1:0]       clr_addr;
  logic [CELL_W-1:0]       map_mem [MAP_DEPTH];
  logic [CELL_W-1:0]       rdata;

  // wall math
  logic [SIDE_W-1:0]             perp_full;
  logic [DIST_W-1:0]             pd_c;
  logic [DIST_W-1:0]             dd_c;
  logic [DIST_W-1:0]             pd;
  logic [TEXID_W-1:0]            tex;
  logic [LH_W-1:0]               lh;
  logic [LH_W-1:0]               lhs;
  logic signed [RAY_W-1:0]       wsel;
  logic signed [DIST_W+RAY_W:0]  wall_prod;
  logic [15:0]                   wall_frac;
  logic [TEX_BITS-1:0]           tx_raw;
  logic                          mirror;
  logic [TEX_BITS-1:0]           tx;
  logic [STP_W-1:0]              stp;
  logic [TP_W-1:0]               tp;
  logic [ROW_W-1:0]              hh;
  logic [LH_W-2:0]               lh2;
  logic                          tall;
  logic [ROW_W-1:0]              ds_c;
  logic [LH_W-1:0]               de_raw;
  logic [ROW_W-1:0]              de_c;
  logic [LH_W-2:0]               factor;
  logic [TP_W+STP_W-1:0]         tp_prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x   <= RST_CAM_X;
      cam_y   <= RST_CAM_Y;
      dir_x   <= RST_DIR_X;
      dir_y   <= RST_DIR_Y;
      plane_x <= RST_PLANE_X;
      plane_y <= RST_PLANE_Y;
      scr_w   <= RST_SCR_W;
      scr_h   <= RST_SCR_H;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAM_X:   cam_x   <= cfg_data[POS_W-1:0];
        REG_CAM_Y:   cam_y   <= cfg_data[POS_W-1:0];
        REG_DIR_X:   dir_x   <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:   dir_y   <= cfg_data[DIR_W-1:0];
        REG_PLANE_X: plane_x <= cfg_data[DIR_W-1:0];
        REG_PLANE_Y: plane_y <= cfg_data[DIR_W-1:0];
        REG_SCR_W:   scr_w   <= cfg_data[SIZE_W-1:0];
        REG_SCR_H:   scr_h   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // screen sizes saturated to the supported range
  always_comb begin
    if (scr_w == '0) w_size = SIZE_W'(1);
    else if (scr_w > SIZE_W'(MAX_COLUMNS)) w_size = SIZE_W'(MAX_COLUMNS);
    else w_size = scr_w;
    if (scr_h == '0) h_size = SIZE_W'(1);
    else if (scr_h > SIZE_W'(ROWS_MAX)) h_size = SIZE_W'(ROWS_MAX);
    else h_size = scr_h;
  end

  // ray magnitudes as divisors, zero replaced by one
  assign abs_x = rdx[RAY_W-1] ? RAY_W'(-rdx) : RAY_W'(rdx);
  assign abs_y = rdy[RAY_W-1] ? RAY_W'(-rdy) : RAY_W'(rdy);
  assign den_x = (rdx == '0) ? DIVD_W'(1) : abs_x[DIVD_W-1:0];
  assign den_y = (rdy == '0) ? DIVD_W'(1) : abs_y[DIVD_W-1:0];

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DIVD_W'(1);
    case (cmd)
      CMD_CAST: begin
        div_start = 1'b1;
        div_num   = DIVN_W'({column, 17'b0});
        div_den   = DIVD_W'(w_size);
      end
      CMD_RAYY: begin
        div_start = 1'b1;
        div_num   = DIV_ONE32;
        div_den   = den_x;
      end
      CMD_DLX: begin
        div_start = 1'b1;
        div_num   = DIV_ONE32;
        div_den   = den_y;
      end
      CMD_PERP: begin
        div_start = 1'b1;
        div_num   = DIVN_W'({h_size, 16'b0});
        div_den   = DIVD_W'(dd_c);
      end
      CMD_WALL: begin
        div_start = 1'b1;
        div_num   = TEX_NUM;
        div_den   = DIVD_W'(lhs);
      end
      default: ;
    endcase
  end

  gdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // ray component: dir + floor(plane * cameraX / 2^16)
  assign psel     = (cmd == CMD_RAYX) ? plane_x : plane_y;
  assign dsel     = (cmd == CMD_RAYX) ? RAY_W'(dir_x) : RAY_W'(dir_y);
  assign ray_prod = psel * camx;
  assign ray_new  = dsel + ray_prod[CAM_W+DIR_W-1:16];

  // initial side distance from the fractional camera position
  assign sd_neg   = (cmd == CMD_SDX) ? rdx[RAY_W-1] : rdy[RAY_W-1];
  assign sd_frac  = (cmd == CMD_SDX) ? cam_x[15:0] : cam_y[15:0];
  assign sd_delta = (cmd == CMD_SDX) ? dlx : dly;
  assign sd_term  = sd_neg ? {1'b0, sd_frac} : (17'h10000 - {1'b0, sd_frac});
  assign sd_prod  = sd_term * sd_delta;

  // one dda step: advance the nearer side
  assign take_x    = (sdx < sdy);
  assign mapx_step = rdx[RAY_W-1] ? (mapx - MAPC_W'(1)) : (mapx + MAPC_W'(1));
  assign mapy_step = rdy[RAY_W-1] ? (mapy - MAPC_W'(1)) : (mapy + MAPC_W'(1));

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_CAMX: camx <= div_q[CAM_W-1:0] - FONE;
      CMD_RAYX: rdx  <= ray_new;
      CMD_RAYY: rdy  <= ray_new;
      CMD_DLX:  dlx  <= (rdx == '0) ? DELTA_SAT : div_q[DELTA_W-1:0];
      CMD_DLY:  dly  <= (rdy == '0) ? DELTA_SAT : div_q[DELTA_W-1:0];
      CMD_SDX: begin
        sdx   <= SIDE_W'(sd_prod[DELTA_W+16:16]);
        mapx  <= MAPC_W'(cam_x[POS_W-1:16]);
        mapy  <= MAPC_W'(cam_y[POS_W-1:16]);
        steps <= '0;
      end
      CMD_SDY:  sdy  <= SIDE_W'(sd_prod[DELTA_W+16:16]);
      CMD_STEP: begin
        steps <= steps + STEP_W'(1);
        if (take_x) begin
          sdx  <= sdx + SIDE_W'(dlx);
          mapx <= mapx_step;
          side <= 1'b0;
        end else begin
          sdy  <= sdy + SIDE_W'(dly);
          mapy <= mapy_step;
          side <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // map memory ports: read follows the cell being stepped into
  always_comb begin
    if (cmd == CMD_STEP) begin
      if (take_x) rd_addr = {mapy[MAP_BITS-1:0], mapx_step[MAP_BITS-1:0]};
      else        rd_addr = {mapy_step[MAP_BITS-1:0], mapx[MAP_BITS-1:0]};
    end else begin
      rd_addr = {mapy[MAP_BITS-1:0], mapx[MAP_BITS-1:0]};
    end
    wr_en   = (cmd == CMD_CLEAR) || (cmd == CMD_WRITE);
    wr_addr = (cmd == CMD_CLEAR) ? clr_addr : {cell_y, cell_x};
    wr_data = (cmd == CMD_CLEAR) ? '0 : {cell_decoration, cell_texture};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= map_mem[rd_addr];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd == CMD_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // perpendicular distance, saturated, and its nonzero divisor
  assign perp_full = side ? (sdy - SIDE_W'(dly)) : (sdx - SIDE_W'(dlx));
  assign pd_c      = (perp_full[SIDE_W-1:DIST_W] != '0) ? DIST_MAX : perp_full[DIST_W-1:0];
  assign dd_c      = (pd_c == '0) ? DIST_W'(1) : pd_c;
  assign lhs       = (lh == '0) ? LH_W'(1) : lh;

  // texture column from the wall hit position
  assign wsel      = side ? rdx : rdy;
  assign wall_prod = $signed({1'b0, pd}) * wsel;
  assign wall_frac = (side ? cam_x[15:0] : cam_y[15:0]) + wall_prod[31:16];
  assign tx_raw    = wall_frac[15:16-TEX_BITS];
  assign mirror    = (!side && !rdx[RAY_W-1] && (rdx != '0)) || (side && rdy[RAY_W-1]);

  // draw span and texture start factor from the line height
  assign hh     = h_size[SIZE_W-1:1];
  assign lh2    = lh[LH_W-1:1];
  assign tall   = (lh2 > (LH_W-1)'(hh));
  assign ds_c   = tall ? '0 : (hh - lh2[ROW_W-1:0]);
  assign de_raw = LH_W'(lh2) + LH_W'(hh);
  assign de_c   = (de_raw >= LH_W'(h_size)) ? ROW_W'(h_size - SIZE_W'(1)) : de_raw[ROW_W-1:0];
  assign factor = tall ? (lh2 - (LH_W-1)'(hh)) : '0;
  assign tp_prod = factor[TP_W-1:0] * stp;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_PERP: begin
        pd  <= pd_c;
        tex <= rdata[TEXID_W-1:0];
      end
      CMD_LH:   lh  <= div_q[LH_W-1:0];
      CMD_WALL: tx  <= mirror ? ~tx_raw : tx_raw;
      CMD_STP:  stp <= div_q[STP_W-1:0];
      CMD_TEXP: tp  <= tp_prod[TP_W-1:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd == CMD_OUT_HIT) || (cmd == CMD_OUT_MISS)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT_HIT) begin
      hit_found     <= 1'b1;
      hit_side      <= side;
      wall_texture  <= tex;
      perp_distance <= pd;
      span_start    <= ds_c;
      span_end      <= de_c;
      texel_column  <= tx;
      texel_step    <= stp;
      texel_start   <= tp;
    end else if (cmd == CMD_OUT_MISS) begin
      hit_found     <= 1'b0;
      hit_side      <= 1'b0;
      wall_texture  <= '0;
      perp_distance <= '0;
      span_start    <= '0;
      span_end      <= '0;
      texel_column  <= '0;
      texel_step    <= '0;
      texel_start   <= '0;
    end
  end

  // status to the controller
  always_comb begin
    status.div_done   = div_done;
    status.clear_last = (clr_addr == '1);
    status.out_free   = !out_valid || !out_stall;
    status.map_oob    = (mapx[MAPC_W-1:MAP_BITS] != '0) || (mapy[MAPC_W-1:MAP_BITS] != '0);
    status.map_wall   = (rdata[TEXID_W-1:0] != '0) && !rdata[CELL_W-1];
    status.steps_done = (steps == STEP_W'(MAX_STEPS));
  end

endmodule

`default_nettype wire

>>> src/grid_dda_wall_column_caster.sv
// grid_dda_wall_column_caster: top level, controller plus datapath
// depends on gdc_pkg, gdc_ctrl, gdc_dp
`timescale 1ns / 1ps
`default_nettype none

// Raycasting wall column engine over a 64 x 64 cell map. After reset the map
// is cleared one cell per cycle, all 4096 cells, with in_stall high; config
// writes are taken during that time. A map write item is written to the map
// memory and leaves the controller idle. A cast walks the ray through at most
// 128 cells. A cast that hits a wall runs five serial divisions (camera x, both
// ray deltas, line height, texture step) on one shared radix-2 divider; a miss
// runs only the first three. Every dda step passes through a stepping state and
// a check state that reads the map memory. The result sits in an output
// register, so the next item is accepted while it waits to be taken; one
// result comes out per cast, none per map write.
module grid_dda_wall_column_caster (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [gdc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [gdc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [gdc_pkg::CELLC_W-1:0]   cell_x,
  input  logic [gdc_pkg::CELLC_W-1:0]   cell_y,
  input  logic [gdc_pkg::TEXID_W-1:0]   cell_texture,
  input  logic                          cell_decoration,
  input  logic [gdc_pkg::COL_W-1:0]     column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit_found,
  output logic                          hit_side,
  output logic [gdc_pkg::TEXID_W-1:0]   wall_texture,
  output logic [gdc_pkg::DIST_W-1:0]    perp_distance,
  output logic [gdc_pkg::ROW_W-1:0]     span_start,
  output logic [gdc_pkg::ROW_W-1:0]     span_end,
  output logic [gdc_pkg::TEX_BITS-1:0]  texel_column,
  output logic [gdc_pkg::STP_W-1:0]     texel_step,
  output logic [gdc_pkg::TP_W-1:0]      texel_start
);
  import gdc_pkg::*;

  cmd_t       cmd;
  dp_status_t status;

  // sequencer
  gdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath
  gdc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .cell_texture    (cell_texture),
    .cell_decoration (cell_decoration),
    .column          (column),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .hit_found       (hit_found),
    .hit_side        (hit_side),
    .wall_texture    (wall_texture),
    .perp_distance   (perp_distance),
    .span_start      (span_start),
    .span_end        (span_end),
    .texel_column    (texel_column),
    .texel_step      (texel_step),
    .texel_start     (texel_start)
  );

endmodule

`default_nettype wire

>>> src/gdc_checker.sv
// gdc_checker: port level checks for the wall column caster
// depends on gdc_pkg; bound to grid_dda_wall_column_caster below
`timescale 1ns / 1ps
`default_nettype none

module gdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          hit_found,
  input logic                          hit_side,
  input logic [gdc_pkg::TEXID_W-1:0]   wall_texture,
  input logic [gdc_pkg::DIST_W-1:0]    perp_distance,
  input logic [gdc_pkg::ROW_W-1:0]     span_start,
  input logic [gdc_pkg::ROW_W-1:0]     span_end,
  input logic [gdc_pkg::TEX_BITS-1:0]  texel_column,
  input logic [gdc_pkg::STP_W-1:0]     texel_step,
  input logic [gdc_pkg::TP_W-1:0]      texel_start
);
  import gdc_pkg::*;

  // a result held back stays
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(perp_distance) && $stable(texel_start))
    else $error("stalled result changed or dropped");

  // a miss carries only zeros
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_found |-> !hit_side && (wall_texture == '0) &&
      (perp_distance == '0) && (span_start == '0) && (span_end == '0) &&
      (texel_column == '0) && (texel_step == '0) && (texel_start == '0))
    else $error("miss result with nonzero fields");

  // the draw span is never inverted
  assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_found |-> span_start <= span_end)
    else $error("span start beyond span end");

  // clearing pass holds off items right after reset
  assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> in_stall)
    else $error("item accepted during map clear");

endmodule

bind grid_dda_wall_column_caster gdc_checker u_gdc_checker (.*);

`default_nettype wire
